### src/assert_macros.svh
// assertion macros of the console writer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define TCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// condition must never be seen at a clock edge out of reset
`define TCW_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

### src/tcw_pkg.sv
// package with constants, codes and types of the text console writer
`default_nettype none

package tcw_pkg;

  // screen geometry
  localparam int unsigned COLUMNS  = 80;
  localparam int unsigned ROWS     = 25;
  localparam int unsigned CELLS    = COLUMNS * ROWS;
  localparam int unsigned TAB_STEP = 4;

  // storage widths
  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam int unsigned CNT_W  = $clog2(CELLS + 1);
  localparam int unsigned CELL_W = 16;

  // field widths of the channels
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned INDEX_W  = 11;
  localparam int unsigned CURSOR_W = 11;
  localparam int unsigned ROW_W    = 5;
  localparam int unsigned COL_W    = 7;
  localparam int unsigned SCROLL_W = 2;

  // column with one spare bit for the step past the row end
  localparam int unsigned COLX_W = COL_W + 1;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

  // item commands
  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // control characters
  localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_VT  = 8'h0B;
  localparam logic [CHAR_W-1:0] CH_FF  = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

  // decoded kind of the current item
  typedef enum logic [2:0] {
    OP_NOP   = 3'd0,
    OP_READ  = 3'd1,
    OP_MOVE  = 3'd2,
    OP_CLEAR = 3'd3,
    OP_PRINT = 3'd4
  } op_e;

  typedef struct packed {
    logic               cmd;
    logic [CHAR_W-1:0]  char_code;
    logic [CHAR_W-1:0]  color;
    logic [INDEX_W-1:0] cell_index;
  } in_t;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_offset;
    logic [ROW_W-1:0]    cursor_row;
    logic [COL_W-1:0]    cursor_column;
    logic [SCROLL_W-1:0] rows_scrolled;
    logic [CELL_W-1:0]   cell_data;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic item_load;
    logic cursor_move;
    logic cursor_home;
    logic cnt_clear;
    logic cnt_step;
    logic fill_blank;
    logic scroll_copy;
    logic scroll_end;
    logic print;
    logic read_issue;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    op_e  op;
    logic row_over;
    logic fill_last;
    logic scroll_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

### src/tcw_if.sv
// valid/ready channel interfaces for put/read items and results
`default_nettype none

interface tcw_in_if;
  import tcw_pkg::*;
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tcw_out_if;
  import tcw_pkg::*;
  logic valid;
  logic ready;
  out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### src/tcw_ram.sv
// generic ram, one write port and one registered read port
`default_nettype none

module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### src/tcw_ctrl.sv
// controller state machine of the text console writer
`default_nettype none

module tcw_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tcw_pkg::dp_status_t status_i,
  output tcw_pkg::dp_cmd_t    cmd_o
);
  import tcw_pkg::*;

  typedef enum logic [7:0] {
    S_INIT   = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_EXEC   = 8'b0000_0100,
    S_CHK    = 8'b0000_1000,
    S_SCROLL = 8'b0001_0000,
    S_CLEAR  = 8'b0010_0000,
    S_WRITE  = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_INIT: begin
        cmd_o.fill_blank = 1'b1;
        cmd_o.cnt_step   = 1'b1;
        if (status_i.fill_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.item_load = 1'b1;
          state_d         = S_EXEC;
        end
      end
      S_EXEC: begin
        case (status_i.op)
          OP_READ: begin
            cmd_o.read_issue = 1'b1;
            state_d          = S_DONE;
          end
          OP_MOVE: begin
            cmd_o.cursor_move = 1'b1;
            state_d           = S_CHK;
          end
          OP_CLEAR: begin
            cmd_o.cursor_home = 1'b1;
            cmd_o.cnt_clear   = 1'b1;
            state_d           = S_CLEAR;
          end
          OP_PRINT: begin
            if (status_i.row_over) begin
              cmd_o.cnt_clear = 1'b1;
              state_d         = S_SCROLL;
            end else begin
              state_d = S_WRITE;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_CHK: begin
        if (status_i.row_over) begin
          cmd_o.cnt_clear = 1'b1;
          state_d         = S_SCROLL;
        end else if (status_i.op == OP_PRINT) begin
          state_d = S_WRITE;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SCROLL: begin
        cmd_o.scroll_copy = 1'b1;
        cmd_o.cnt_step    = 1'b1;
        if (status_i.scroll_last) begin
          cmd_o.scroll_end = 1'b1;
          state_d          = S_CHK;
        end
      end
      S_CLEAR: begin
        cmd_o.fill_blank = 1'b1;
        cmd_o.cnt_step   = 1'b1;
        if (status_i.fill_last) begin
          state_d = S_DONE;
        end
      end
      S_WRITE: begin
        cmd_o.print = 1'b1;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### src/tcw_datapath.sv
// datapath: item register, cursor, sweep counter, ram access and result register
`default_nettype none
`include "assert_macros.svh"

module tcw_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tcw_pkg::in_t               in_data_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output tcw_pkg::out_t              out_data_o,
  input  tcw_pkg::dp_cmd_t           cmd_i,
  output tcw_pkg::dp_status_t        status_o,
  output logic                       ram_we_o,
  output logic [tcw_pkg::ADDR_W-1:0] ram_waddr_o,
  output logic [tcw_pkg::CELL_W-1:0] ram_wdata_o,
  output logic                       ram_re_o,
  output logic [tcw_pkg::ADDR_W-1:0] ram_raddr_o,
  input  logic [tcw_pkg::CELL_W-1:0] ram_rdata_i
);
  import tcw_pkg::*;

  in_t                 item_q;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic [SCROLL_W-1:0] scrolls_q, scrolls_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                out_valid_q;
  out_t                out_q;

  op_e                 op;
  logic [COLX_W-1:0]   col_tab;
  logic [COLX_W-1:0]   col_inc;
  logic [CURSOR_W-1:0] cur_offset;
  logic [CNT_W-1:0]    cnt_prev;
  logic                in_range;
  logic                out_free;
  logic                no_scroll;
  logic                cur_on_screen;

  // item kind
  always_comb begin
    if (item_q.cmd == CMD_READ) begin
      op = OP_READ;
    end else begin
      case (item_q.char_code)
        CH_NUL:                            op = OP_NOP;
        CH_FF:                             op = OP_CLEAR;
        CH_BS, CH_TAB, CH_LF, CH_VT, CH_CR: op = OP_MOVE;
        default:                           op = OP_PRINT;
      endcase
    end
  end

  assign col_tab    = {1'b0, col_q} + COLX_W'(TAB_STEP);
  assign col_inc    = {1'b0, col_q} + COLX_W'(1);
  assign cur_offset = CURSOR_W'(row_q) * CURSOR_W'(COLUMNS) + CURSOR_W'(col_q);
  assign cnt_prev   = cnt_q - CNT_W'(1);
  assign in_range   = item_q.cell_index < INDEX_W'(CELLS);
  assign out_free   = !out_valid_q || out_ready_i;

  // backspace and carriage return leave a cursor parked past the screen in place
  assign no_scroll  = (op == OP_MOVE) && (item_q.char_code inside {CH_BS, CH_CR});

  // cursor is on screen or parked at column 0 just past the last row
  assign cur_on_screen = (row_q < ROW_W'(ROWS)) || (row_q == ROW_W'(ROWS) && col_q == '0);

  // cursor kept as row and column
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (cmd_i.cursor_home) begin
      row_d = '0;
      col_d = '0;
    end else if (cmd_i.cursor_move) begin
      case (item_q.char_code)
        CH_LF: begin
          row_d = row_q + ROW_W'(1);
          col_d = '0;
        end
        CH_CR: begin
          col_d = '0;
        end
        CH_TAB: begin
          if (col_tab >= COLX_W'(COLUMNS)) begin
            col_d = COL_W'(col_tab - COLX_W'(COLUMNS));
            row_d = row_q + ROW_W'(1);
          end else begin
            col_d = COL_W'(col_tab);
          end
        end
        CH_VT: begin
          row_d = row_q + ROW_W'(1);
        end
        CH_BS: begin
          if (col_q != '0) begin
            col_d = col_q - COL_W'(1);
          end
        end
        default: begin
          col_d = col_q;
        end
      endcase
    end else if (cmd_i.print) begin
      if (col_inc == COLX_W'(COLUMNS)) begin
        col_d = '0;
        row_d = row_q + ROW_W'(1);
      end else begin
        col_d = COL_W'(col_inc);
      end
    end else if (cmd_i.scroll_end) begin
      row_d = row_q - ROW_W'(1);
    end
  end

  always_comb begin
    scrolls_d = scrolls_q;
    if (cmd_i.item_load) begin
      scrolls_d = '0;
    end else if (cmd_i.scroll_end) begin
      scrolls_d = scrolls_q + SCROLL_W'(1);
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_clear) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_step) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  // ram ports; the scroll reads one row ahead and writes the cell behind
  always_comb begin
    ram_we_o    = 1'b0;
    ram_waddr_o = cnt_q[ADDR_W-1:0];
    ram_wdata_o = BLANK_CELL;
    ram_re_o    = 1'b0;
    ram_raddr_o = '0;
    if (cmd_i.fill_blank) begin
      ram_we_o = 1'b1;
    end else if (cmd_i.scroll_copy) begin
      ram_we_o    = cnt_q != '0;
      ram_waddr_o = cnt_prev[ADDR_W-1:0];
      if (cnt_prev < CNT_W'(CELLS - COLUMNS)) begin
        ram_wdata_o = ram_rdata_i;
      end
    end else if (cmd_i.print) begin
      ram_we_o    = 1'b1;
      ram_waddr_o = ADDR_W'(cur_offset);
      ram_wdata_o = {item_q.color, item_q.char_code};
    end
    if (cmd_i.scroll_copy && (cnt_q < CNT_W'(CELLS - COLUMNS))) begin
      ram_re_o    = 1'b1;
      ram_raddr_o = ADDR_W'(cnt_q + CNT_W'(COLUMNS));
    end else if (cmd_i.read_issue && in_range) begin
      ram_re_o    = 1'b1;
      ram_raddr_o = ADDR_W'(item_q.cell_index);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      item_q <= in_data_i;
    end
    scrolls_q <= scrolls_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      cnt_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
      cnt_q <= cnt_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.cursor_offset <= cur_offset;
      out_q.cursor_row    <= row_q;
      out_q.cursor_column <= col_q;
      out_q.rows_scrolled <= scrolls_q;
      out_q.cell_data     <= (op == OP_READ && in_range) ? ram_rdata_i : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign status_o.op          = op;
  assign status_o.row_over    = (row_q >= ROW_W'(ROWS)) && !no_scroll;
  assign status_o.fill_last   = cnt_q == CNT_W'(CELLS - 1);
  assign status_o.scroll_last = cnt_q == CNT_W'(CELLS);
  assign status_o.out_free    = out_free;

  `TCW_ASSERT(a_print_on_screen, cmd_i.print |-> row_q < ROW_W'(ROWS), "print off screen")
  `TCW_ASSERT(a_result_cursor, cmd_i.out_load |-> cur_on_screen, "result cursor past end")
  `TCW_ASSERT_NEVER(a_scroll_limit, cmd_i.scroll_end && scrolls_q == 2'd2, "over two scrolls")

endmodule

`default_nettype wire

### src/text_console_writer.sv
// top level of the text console writer: 80x25 cell screen with a linear cursor
//
// in_i carries one transaction per item: cmd selects put character or read cell,
// with char_code, color and cell_index. out_o returns exactly one transaction per
// item: cursor offset, row and column after the item, rows scrolled and, for a
// read, the cell (zero for a put or an index past the screen).
// a put of a printable code steps through the exec, write and done states, a cursor
// code through exec, check and done; a read goes from exec straight to done.
// each scroll walks the screen ram through its single write port, one cell a
// cycle, once per row scrolled (at most two per item).
// form feed refills all 2000 cells.
// after reset a clearing pass writes blanks to all 2000 cells; in_i.ready stays
// low for the whole pass, then the cursor sits at offset 0.
// the result register decouples the sides: a new item is taken while a result
// waits, and the item after that holds in its final state until out_o drains.
`default_nettype none

module text_console_writer (
  input  logic      clk_i,
  input  logic      rst_ni,
  tcw_in_if.sink    in_i,
  tcw_out_if.source out_o
);
  import tcw_pkg::*;

  dp_cmd_t            cmd;
  dp_status_t         status;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [CELL_W-1:0]  ram_wdata;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [CELL_W-1:0]  ram_rdata;

  // sequencing of items, sweeps and the result handshake
  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // cursor arithmetic, address generation and result register
  tcw_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_i.data),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.data),
    .cmd_i       (cmd),
    .status_o    (status),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // screen cells, attribute in the high byte
  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

### verif/text_console_writer_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the text console writer with its own screen model and scoreboard
module text_console_writer_tb;
  import tcw_pkg::*;

  localparam int unsigned CLK_PERIOD     = 8;
  localparam int unsigned RESET_CYCLES   = 11;
  // three idle profiles of about this many transactions each
  localparam int unsigned PHASE_ITEMS    = 317;
  // long receiver hold-off so the result register fills and in_i stalls
  localparam int unsigned HOLD_CYCLES    = 400;
  // a double scroll walks the ram twice; form feed and the clearing pass after
  // reset walk it once; plus the long hold-off, several times over
  localparam int unsigned WATCHDOG_LIMIT = 30000;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned MAX_REPORTS    = 40;
  localparam int unsigned INDEX_MAX      = (1 << INDEX_W) - 1;

  logic clk_i = 1'b0;
  logic rst_ni;

  tcw_in_if  in_bus ();
  tcw_out_if out_bus ();

  text_console_writer u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // screen model: cells and linear cursor, updated once per accepted transaction
  logic [CELL_W-1:0] screen_mem [CELLS];
  int unsigned       cursor_at;

  // transactions waiting for the sender, and console results still owed by the block
  in_t  pending_items_q[$];
  out_t expected_results_q[$];

  int unsigned items_queued;
  int unsigned mismatches;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  // the stimulus side asks for a hold-off by bumping hold_requests,
  // the receiver process serves it and counts the cycles itself
  int unsigned hold_requests;
  int unsigned holds_served;
  int unsigned hold_left;
  int unsigned stall_cycles;

  logic [CHAR_W-1:0] motion_codes [6] = '{CH_NUL, CH_BS, CH_TAB, CH_LF, CH_VT, CH_CR};

  // ---------------------------------------------------------------------------
  // screen model
  // ---------------------------------------------------------------------------

  function automatic void blank_screen();
    for (int unsigned i = 0; i < CELLS; i++) screen_mem[i] = BLANK_CELL;
  endfunction

  // while the cursor sits past the last row: shift all rows up, blank the
  // bottom row and pull the cursor back one row; returns rows scrolled
  function automatic int unsigned scroll_until_visible();
    int unsigned rolled;
    rolled = 0;
    while (cursor_at >= CELLS) begin
      for (int unsigned i = 0; i < CELLS - COLUMNS; i++) screen_mem[i] = screen_mem[i + COLUMNS];
      for (int unsigned i = CELLS - COLUMNS; i < CELLS; i++) screen_mem[i] = BLANK_CELL;
      cursor_at -= COLUMNS;
      rolled++;
    end
    return rolled;
  endfunction

  // apply one transaction to the model and return the result it should produce
  function automatic out_t console_apply(in_t item);
    out_t        res;
    int unsigned rolled;
    logic [CELL_W-1:0] read_word;
    rolled    = 0;
    read_word = '0;
    if (item.cmd == CMD_READ) begin
      // cells past the screen read as zero
      if (item.cell_index < CELLS) read_word = screen_mem[item.cell_index];
    end else begin
      case (item.char_code)
        CH_NUL: begin
        end
        CH_LF: begin
          cursor_at = cursor_at + COLUMNS - cursor_at % COLUMNS;
          rolled    = scroll_until_visible();
        end
        CH_FF: begin
          blank_screen();
          cursor_at = 0;
        end
        CH_CR: begin
          cursor_at -= cursor_at % COLUMNS;
        end
        CH_TAB: begin
          cursor_at += TAB_STEP;
          rolled     = scroll_until_visible();
        end
        CH_VT: begin
          cursor_at += COLUMNS;
          rolled     = scroll_until_visible();
        end
        CH_BS: begin
          if (cursor_at % COLUMNS != 0) cursor_at -= 1;
        end
        default: begin
          // a glyph scrolls first, then writes, so the cursor may rest one past the screen
          rolled = scroll_until_visible();
          if (cursor_at < CELLS) screen_mem[cursor_at] = {item.color, item.char_code};
          cursor_at += 1;
        end
      endcase
    end
    res.cursor_offset = CURSOR_W'(cursor_at);
    res.cursor_row    = ROW_W'(cursor_at / COLUMNS);
    res.cursor_column = COL_W'(cursor_at % COLUMNS);
    res.rows_scrolled = SCROLL_W'(rolled);
    res.cell_data     = read_word;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // sender: one transaction at a time from pending_items_q, random gaps
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
      in_bus.data  <= '0;
    end else begin
      // accepted at this edge: the model moves on and owes one result
      if (in_bus.valid && in_bus.ready) begin
        expected_results_q.push_back(console_apply(in_bus.data));
      end
      // valid only drops once the offered transaction is taken
      if (!in_bus.valid || in_bus.ready) begin
        if (pending_items_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_bus.data  <= pending_items_q.pop_front();
          in_bus.valid <= 1'b1;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random back-pressure, plus the long hold-off on request
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      hold_left     <= 0;
      holds_served  <= 0;
    end else if (holds_served != hold_requests) begin
      holds_served  <= holds_served + 1;
      hold_left     <= HOLD_CYCLES;
      out_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t ns mismatch %s: got %0d (0x%0h) want %0d (0x%0h)",
               $realtime, what, got, got, want, want);
  endtask

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (expected_results_q.size() == 0) begin
        note_mismatch("unexpected result, cursor_offset", out_bus.data.cursor_offset, 0);
      end else begin
        want = expected_results_q.pop_front();
        if (out_bus.data.cursor_offset !== want.cursor_offset)
          note_mismatch("cursor_offset", out_bus.data.cursor_offset, want.cursor_offset);
        if (out_bus.data.cursor_row !== want.cursor_row)
          note_mismatch("cursor_row", out_bus.data.cursor_row, want.cursor_row);
        if (out_bus.data.cursor_column !== want.cursor_column)
          note_mismatch("cursor_column", out_bus.data.cursor_column, want.cursor_column);
        if (out_bus.data.rows_scrolled !== want.rows_scrolled)
          note_mismatch("rows_scrolled", out_bus.data.rows_scrolled, want.rows_scrolled);
        if (out_bus.data.cell_data !== want.cell_data)
          note_mismatch("cell_data", out_bus.data.cell_data, want.cell_data);
      end
    end
  end

  // watchdog: ends the run when neither side moves a transaction for too long
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_cycles <= 0;
    end else if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("text_console_writer regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  function automatic in_t put_item(logic [CHAR_W-1:0] code, logic [CHAR_W-1:0] color);
    in_t item;
    item.cmd        = CMD_PUT;
    item.char_code  = code;
    item.color      = color;
    item.cell_index = INDEX_W'($urandom);
    return item;
  endfunction

  function automatic in_t read_item(int unsigned index);
    in_t item;
    item.cmd        = CMD_READ;
    item.char_code  = CHAR_W'($urandom);
    item.color      = CHAR_W'($urandom);
    item.cell_index = INDEX_W'(index);
    return item;
  endfunction

  // any printable byte, i.e. anything but nul and the control codes
  function automatic logic [CHAR_W-1:0] pick_glyph();
    logic [CHAR_W-1:0] code;
    do code = CHAR_W'($urandom_range(1, 255));
    while (code inside {CH_BS, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR});
    return code;
  endfunction

  function automatic in_t glyph_item();
    return put_item(pick_glyph(), CHAR_W'($urandom));
  endfunction

  function automatic in_t motion_item();
    return put_item(motion_codes[$urandom_range(0, 5)], CHAR_W'($urandom));
  endfunction

  // mostly on-screen reads, some past the end of the screen
  function automatic in_t random_read();
    if ($urandom_range(99) < 85) return read_item($urandom_range(0, CELLS - 1));
    return read_item($urandom_range(CELLS, INDEX_MAX));
  endfunction

  task automatic offer(input in_t item);
    pending_items_q.push_back(item);
    items_queued++;
  endtask

  // sender has handed over every queued transaction, so the model is current
  task automatic wait_sender_idle();
    do @(negedge clk_i);
    while (pending_items_q.size() != 0 || in_bus.valid);
  endtask

  // a run of text with the odd cursor code mixed in
  task automatic text_burst();
    int unsigned count;
    count = $urandom_range(1, 60);
    repeat (count) begin
      if ($urandom_range(99) < 12) offer(motion_item());
      else offer(glyph_item());
    end
  endtask

  // walk down to the bottom row and type across the end of the screen, so the
  // cursor lands on or near the parking spot past the last cell; then one
  // more transaction that may have to scroll from there (two rows for newline and
  // vertical tab out of the parking spot)
  task automatic bottom_burst();
    int unsigned row_now;
    int unsigned rows_down;
    int unsigned count;
    row_now   = cursor_at / COLUMNS;
    rows_down = (row_now >= ROWS - 1) ? 0 : ROWS - 1 - row_now;
    rows_down += $urandom_range(0, 1);
    repeat (rows_down) offer(put_item($urandom_range(1) ? CH_VT : CH_LF, CHAR_W'($urandom)));
    offer(put_item(CH_CR, CHAR_W'($urandom)));
    count = $urandom_range(1) ? COLUMNS : $urandom_range(COLUMNS - 3, COLUMNS + 3);
    repeat (count) offer(glyph_item());
    case ($urandom_range(0, 7))
      0: offer(put_item(CH_LF, CHAR_W'($urandom)));
      1: offer(put_item(CH_VT, CHAR_W'($urandom)));
      2: offer(put_item(CH_TAB, CHAR_W'($urandom)));
      3: offer(put_item(CH_BS, CHAR_W'($urandom)));
      4: offer(put_item(CH_CR, CHAR_W'($urandom)));
      5: offer(read_item(CELLS - 1));
      default: offer(glyph_item());
    endcase
  endtask

  // short cursor moves within a row: tab, backspace, carriage return, text
  task automatic column_burst();
    int unsigned count;
    count = $urandom_range(1, 15);
    repeat (count) begin
      case ($urandom_range(0, 3))
        0: offer(put_item(CH_TAB, CHAR_W'($urandom)));
        1: offer(put_item(CH_BS, CHAR_W'($urandom)));
        2: offer(put_item(CH_CR, CHAR_W'($urandom)));
        default: offer(glyph_item());
      endcase
    end
  endtask

  // unshaped transactions: every field fully random
  task automatic noise_burst();
    int unsigned count;
    in_t item;
    count = $urandom_range(1, 10);
    repeat (count) begin
      item.cmd        = 1'($urandom);
      item.char_code  = CHAR_W'($urandom);
      item.color      = CHAR_W'($urandom);
      item.cell_index = INDEX_W'($urandom);
      offer(item);
    end
  endtask

  task automatic random_burst();
    int unsigned pick;
    int unsigned count;
    pick = $urandom_range(99);
    if (pick < 40) text_burst();
    else if (pick < 55) bottom_burst();
    else if (pick < 70) begin
      count = $urandom_range(1, 12);
      repeat (count) offer(random_read());
    end
    else if (pick < 82) column_burst();
    else if (pick < 86) offer(put_item(CH_FF, CHAR_W'($urandom)));
    else noise_burst();
    wait_sender_idle();
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_bus.valid  = 1'b0;
    in_bus.data   = '0;
    out_bus.ready = 1'b0;
    items_queued  = 0;
    mismatches    = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests = 0;
    cursor_at     = 0;
    blank_screen();

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int phase = 0; phase < 3; phase++) begin
      // sender 20 / receiver 74, then swapped, then no idling at all
      send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 74 : 0;
      recv_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 20 : 0;

      if (phase == 0) begin
        // directed: fresh screen, out-of-range reads, nul, cursor codes at
        // column 0, extreme character and colour bytes, form feed
        offer(read_item(0));
        offer(read_item(CELLS - 1));
        offer(read_item(CELLS));
        offer(read_item(INDEX_MAX));
        offer(put_item(CH_NUL, 8'hFF));
        offer(put_item(CH_BS, 8'h00));
        offer(put_item(CH_CR, 8'h00));
        offer(put_item(8'hFF, 8'hFF));
        offer(put_item(8'h01, 8'h00));
        offer(put_item(8'h7F, 8'h80));
        offer(put_item(CH_BS, 8'h00));
        offer(read_item(2));
        offer(read_item(0));
        offer(put_item(CH_TAB, 8'h00));
        offer(put_item(CH_CR, 8'h00));
        offer(put_item(CH_LF, 8'h00));
        offer(put_item(CH_VT, 8'h00));
        offer(put_item(CH_BS, 8'h00));
        offer(put_item(CH_FF, 8'h00));
        offer(read_item(0));
        offer(read_item(1));
        wait_sender_idle();
        bottom_burst();
        wait_sender_idle();
      end

      if (phase == 2) begin
        // receiver goes quiet while text keeps coming
        hold_requests++;
        repeat (40) offer(glyph_item());
        wait_sender_idle();
      end

      while (items_queued < (phase + 1) * PHASE_ITEMS) random_burst();
    end

    // let every owed result come back, then watch a little longer for strays
    wait_sender_idle();
    while (expected_results_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (expected_results_q.size() != 0)
      note_mismatch("results never returned", 0, expected_results_q.size());

    if (mismatches == 0) begin
      $display("text_console_writer regression: pass");
    end else begin
      $display("text_console_writer regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/tcw_pkg.sv
src/tcw_if.sv
src/tcw_ram.sv
src/tcw_ctrl.sv
src/tcw_datapath.sv
src/text_console_writer.sv
verif/text_console_writer_tb.sv
